// ===== src/lmre_pkg.sv =====
`timescale 1ns / 1ps

package lmre_pkg;

   localparam int unsigned LAYER_SLOTS = 16;
   localparam int unsigned COLOUR_W    = 16;
   localparam int unsigned INDEX_W     = 4;
   localparam int unsigned RUN_LEN_W   = 17;
   localparam int unsigned BURST_MAX   = 6;
   localparam int unsigned BURST_CNT_W = 3;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [RUN_LEN_W-1:0] RUN_CAP         = 17'd65551;
   localparam logic [RUN_LEN_W-1:0] SHORT_RUN_LIMIT = 17'd16;
   localparam logic [3:0]           LONG_RUN_MARK   = 4'hF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUM_LAYERS     = 3'd0,
      CSR_COLOURS_0_3    = 3'd1,
      CSR_COLOURS_4_7    = 3'd2,
      CSR_COLOURS_8_11   = 3'd3,
      CSR_COLOURS_12_15  = 3'd4
   } csr_index_type;

   typedef logic [LAYER_SLOTS-1:0][COLOUR_W-1:0] colour_table_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      cnt;
   } run_code_type;

   // First configured layer whose colour matches; otherwise the layer count,
   // which wraps to zero when all slots are in use.
   function automatic logic [INDEX_W-1:0] layer_index(
      logic [COLOUR_W-1:0] colour,
      logic [4:0]          count,
      colour_table_type    colours
   );
      logic [INDEX_W-1:0] n;
      n = (count >= 5'(LAYER_SLOTS)) ? '0 : count[INDEX_W-1:0];
      for (int i = LAYER_SLOTS - 1; i >= 0; i--) begin
         if ((5'(i) < count) && (colours[i] == colour)) begin
            n = INDEX_W'(i);
         end
      end
      return n;
   endfunction

   // A short run packs into one byte; a long run takes a marker byte and a
   // big-endian 16-bit remainder.
   function automatic run_code_type encode_run(
      logic [INDEX_W-1:0]   idx,
      logic [RUN_LEN_W-1:0] len
   );
      run_code_type         rc;
      logic [RUN_LEN_W-1:0] lm1;
      logic [RUN_LEN_W-1:0] rest;
      rc   = '0;
      lm1  = (len == '0) ? '0 : len - 17'd1;
      rest = len - SHORT_RUN_LIMIT;
      if (len < SHORT_RUN_LIMIT) begin
         rc.bytes[0] = {lm1[3:0], idx};
         rc.cnt      = 2'd1;
      end else begin
         rc.bytes[0] = {LONG_RUN_MARK, idx};
         rc.bytes[1] = rest[15:8];
         rc.bytes[2] = rest[7:0];
         rc.cnt      = 2'd3;
      end
      return rc;
   endfunction

endpackage

// ===== src/lmre_if.sv =====
`timescale 1ns / 1ps

interface lmre_req_if;
   import lmre_pkg::*;

   logic                valid;
   logic                ready;
   logic [COLOUR_W-1:0] pixel_colour;
   logic                final_pixel;

   modport source (output valid, output pixel_colour, output final_pixel, input ready);
   modport sink   (input valid, input pixel_colour, input final_pixel, output ready);
endinterface

interface lmre_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       last_of_burst;
   logic       end_of_image;

   modport source (output valid, output code_byte, output last_of_burst,
                   output end_of_image, input ready);
   modport sink   (input valid, input code_byte, input last_of_burst,
                   input end_of_image, output ready);
endinterface

interface lmre_csr_if;
   import lmre_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/layer_map_rle_encoder_core.sv =====
`timescale 1ns / 1ps

// A transferred pixel is registered, then its code bytes are registered into the byte buffer.
// Throughput: one pixel per cycle while pixels only extend runs and no bytes wait; a pixel
// that ends runs queues up to six bytes, which the byte-wide output drains before the next.
// Reset (synchronous, active high) clears the open run, empties the byte buffer and clears all
// configuration registers; no run is open after reset.
module layer_map_rle_encoder_core (
   input  logic            clock,
   input  logic            reset,
   lmre_req_if.sink        req_bus,
   lmre_rsp_if.source      rsp_bus,
   lmre_csr_if.sink        csr_bus
);
   import lmre_pkg::*;

   logic [4:0]                num_layers_ff;
   colour_table_type          layer_colour_ff;

   logic                      in_valid_ff;
   logic [COLOUR_W-1:0]       in_colour_ff;
   logic                      in_final_ff;

   logic [COLOUR_W-1:0]       run_colour_ff, run_colour_in;
   logic [RUN_LEN_W-1:0]      run_length_ff, run_length_in;
   logic                      run_open_ff,   run_open_in;

   logic [BURST_MAX-1:0][7:0] burst_ff,  burst_in;
   logic [BURST_CNT_W-1:0]    cnt_ff,    cnt_in;
   logic [BURST_CNT_W-1:0]    ptr_ff;
   logic                      fin_ff;

   logic                      rsp_fire;
   logic                      last_byte;
   logic                      burst_free;
   logic                      process;
   logic                      change;
   logic                      emit_a;
   logic                      emit_b;
   run_code_type              code_a;
   run_code_type              code_b;
   logic [BURST_CNT_W-1:0]    base_b;

   assign csr_bus.ready = 1'b1;

   assign last_byte  = (ptr_ff == cnt_ff - 3'd1);
   assign rsp_fire   = rsp_bus.valid && rsp_bus.ready;
   assign burst_free = (cnt_ff == '0) || (rsp_fire && last_byte);
   assign process    = in_valid_ff && burst_free;
   assign req_bus.ready = !in_valid_ff || process;

   assign rsp_bus.valid         = (cnt_ff != '0);
   assign rsp_bus.code_byte     = burst_ff[ptr_ff];
   assign rsp_bus.last_of_burst = last_byte;
   assign rsp_bus.end_of_image  = last_byte && fin_ff;

   always_comb begin
      change        = run_open_ff && (in_colour_ff != run_colour_ff);
      emit_a        = change;
      code_a        = encode_run(layer_index(run_colour_ff, num_layers_ff, layer_colour_ff),
                                 run_length_ff);
      if (run_open_ff && !change) begin
         run_colour_in = run_colour_ff;
         run_length_in = run_length_ff + 17'd1;
      end else begin
         run_colour_in = in_colour_ff;
         run_length_in = 17'd1;
      end
      emit_b      = (run_length_in >= RUN_CAP) || in_final_ff;
      run_open_in = !emit_b;
      code_b      = encode_run(layer_index(run_colour_in, num_layers_ff, layer_colour_ff),
                               run_length_in);

      base_b   = emit_a ? BURST_CNT_W'(code_a.cnt) : '0;
      burst_in = '0;
      if (emit_a) begin
         for (int k = 0; k < 3; k++) begin
            burst_in[k] = code_a.bytes[k];
         end
      end
      if (emit_b) begin
         for (int k = 0; k < 3; k++) begin
            burst_in[base_b + BURST_CNT_W'(k)] = code_b.bytes[k];
         end
      end
      cnt_in = base_b + (emit_b ? BURST_CNT_W'(code_b.cnt) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_layers_ff   <= '0;
         layer_colour_ff <= '0;
         in_valid_ff     <= 1'b0;
         run_colour_ff   <= '0;
         run_length_ff   <= '0;
         run_open_ff     <= 1'b0;
         cnt_ff          <= '0;
         ptr_ff          <= '0;
         fin_ff          <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            unique case (csr_bus.index)
               CSR_NUM_LAYERS:    num_layers_ff          <= csr_bus.data[4:0];
               CSR_COLOURS_0_3:   layer_colour_ff[3:0]   <= csr_bus.data;
               CSR_COLOURS_4_7:   layer_colour_ff[7:4]   <= csr_bus.data;
               CSR_COLOURS_8_11:  layer_colour_ff[11:8]  <= csr_bus.data;
               CSR_COLOURS_12_15: layer_colour_ff[15:12] <= csr_bus.data;
               default: ;
            endcase
         end

         if (req_bus.valid && req_bus.ready) begin
            in_valid_ff  <= 1'b1;
            in_colour_ff <= req_bus.pixel_colour;
            in_final_ff  <= req_bus.final_pixel;
         end else if (process) begin
            in_valid_ff <= 1'b0;
         end

         if (process) begin
            run_colour_ff <= run_colour_in;
            run_length_ff <= run_length_in;
            run_open_ff   <= run_open_in;
            burst_ff      <= burst_in;
            cnt_ff        <= cnt_in;
            ptr_ff        <= '0;
            fin_ff        <= in_final_ff;
         end else if (rsp_fire) begin
            if (last_byte) begin
               cnt_ff <= '0;
               ptr_ff <= '0;
            end else begin
               ptr_ff <= ptr_ff + 3'd1;
            end
         end
      end
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import lmre_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [7:0] LONG_RUN_BASE = 8'd240;
   localparam logic [2:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CSR_SPARE_LAST  = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [7:0] code;
      logic       last;
      logic       eoi;
   } code_item_type;

   class rle_code_scoreboard;
      code_item_type expected_codes[$];
      code_item_type burst[$];
      logic [4:0]  layer_count;
      logic [63:0] colour_words[4];
      logic [15:0] run_colour;
      logic [16:0] run_length;
      bit          run_open;
      int          errors;
      int          pixels_noted;
      int          images_noted;
      int          bytes_checked;
      int          writes_noted;

      function new();
         layer_count = '0;
         foreach (colour_words[i]) colour_words[i] = '0;
         run_colour = '0;
         run_length = '0;
         run_open = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] data);
         writes_noted++;
         case (idx)
            CSR_NUM_LAYERS:    layer_count = data[4:0];
            CSR_COLOURS_0_3:   colour_words[0] = data;
            CSR_COLOURS_4_7:   colour_words[1] = data;
            CSR_COLOURS_8_11:  colour_words[2] = data;
            CSR_COLOURS_12_15: colour_words[3] = data;
            default: ;
         endcase
      endfunction

      function logic [15:0] slot_colour(int slot);
         return colour_words[slot / 4][(slot % 4) * 16 +: 16];
      endfunction

      function logic [3:0] map_colour(logic [15:0] colour);
         int count;
         int n;
         count = layer_count;
         if (count > LAYER_SLOTS) count = LAYER_SLOTS;
         n = count;
         for (int i = count - 1; i >= 0; i--) begin
            if (slot_colour(i) == colour) n = i;
         end
         if (n > 15) n = 0;
         return n[3:0];
      endfunction

      function void close_run();
         logic [3:0]  idx;
         logic [16:0] rest;
         idx = map_colour(run_colour);
         if (run_length < 16) begin
            burst.push_back('{code: {4'(run_length - 17'd1), idx}, last: 0, eoi: 0});
         end else begin
            rest = run_length - 17'd16;
            burst.push_back('{code: LONG_RUN_BASE + 8'(idx), last: 0, eoi: 0});
            burst.push_back('{code: rest[15:8], last: 0, eoi: 0});
            burst.push_back('{code: rest[7:0], last: 0, eoi: 0});
         end
         run_open = 0;
      endfunction

      function void note_pixel(logic [15:0] colour, bit closes_image);
         burst.delete();
         pixels_noted++;
         if (closes_image) images_noted++;
         if (run_open && colour != run_colour) close_run();
         if (run_open) begin
            run_length = run_length + 17'd1;
         end else begin
            run_colour = colour;
            run_length = 17'd1;
            run_open = 1;
         end
         if (run_length >= RUN_CAP) close_run();
         if (closes_image && run_open) close_run();
         if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1;
            burst[burst.size() - 1].eoi = closes_image;
         end
         foreach (burst[i]) expected_codes.push_back(burst[i]);
      endfunction

      function void flag_field(string field, logic [7:0] want, logic [7:0] got);
         errors++;
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
      endfunction

      function void check_byte(logic [7:0] code, logic last, logic eoi);
         code_item_type want;
         if (expected_codes.size() == 0) begin
            errors++;
            $error("code byte %0h arrived with no byte expected", code);
            return;
         end
         want = expected_codes.pop_front();
         bytes_checked++;
         if (code !== want.code) flag_field("code_byte", want.code, code);
         if (last !== want.last) flag_field("last_of_burst", 8'(want.last), 8'(last));
         if (eoi !== want.eoi) flag_field("end_of_image", 8'(want.eoi), 8'(eoi));
      endfunction

      function int pending();
         return expected_codes.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   lmre_req_if req_ch();
   lmre_rsp_if rsp_ch();
   lmre_csr_if csr_ch();

   layer_map_rle_encoder_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   rle_code_scoreboard sb = new();
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int receiver_hold      = 0;
   int cycles             = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // The receiver samples the bus before deciding on the next cycle's ready.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            sb.check_byte(rsp_ch.code_byte, rsp_ch.last_of_burst, rsp_ch.end_of_image);
         end
         if (receiver_hold > 0) begin
            receiver_hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 57;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 57;
         end
         default: begin
            sender_idle_pct = 9;
            receiver_stall_pct = 9;
         end
      endcase
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(idx, data);
   endtask

   task automatic load_config(logic [4:0] count, logic [63:0] w0, logic [63:0] w1,
                              logic [63:0] w2, logic [63:0] w3);
      write_reg(CSR_NUM_LAYERS, 64'(count));
      write_reg(CSR_COLOURS_0_3, w0);
      write_reg(CSR_COLOURS_4_7, w1);
      write_reg(CSR_COLOURS_8_11, w2);
      write_reg(CSR_COLOURS_12_15, w3);
      for (int i = CSR_SPARE_FIRST; i <= CSR_SPARE_LAST; i++) begin
         write_reg(3'(i), {$urandom, $urandom});
      end
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_pixel(logic [15:0] colour, bit closes_image);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.pixel_colour <= colour;
      req_ch.final_pixel  <= closes_image;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_pixel(colour, closes_image);
   endtask

   task automatic send_run(logic [15:0] colour, int length, bit closes_image);
      for (int i = 1; i <= length; i++) begin
         send_pixel(colour, closes_image && (i == length));
      end
   endtask

   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_traffic(int pixels);
      int          sent;
      int          len;
      int          r;
      logic [15:0] colour;
      logic [15:0] prev;
      sent = 0;
      prev = '0;
      while (sent < pixels) begin
         r = $urandom_range(99);
         if (r < 60) colour = sb.slot_colour($urandom_range(15));
         else if (r < 72) colour = prev;
         else colour = 16'($urandom_range(16'hFFFF));
         r = $urandom_range(99);
         if (r < 50) len = 1;
         else if (r < 80) len = $urandom_range(4, 2);
         else if (r < 95) len = $urandom_range(15, 5);
         else len = $urandom_range(40, 16);
         send_run(colour, len, $urandom_range(9) == 0);
         prev = colour;
         sent += len;
      end
      send_pixel(16'($urandom_range(16'hFFFF)), 1'b1);
   endtask

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.pixel_colour <= '0;
      req_ch.final_pixel  <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= CSR_NUM_LAYERS;
      csr_ch.data         <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(IDLE_NONE);
      send_pixel(16'h0000, 1'b1);
      send_run(16'hFFFF, 2, 1'b0);
      send_pixel(16'h1234, 1'b1);
      drain_block();

      // Layer 3 repeats layer 0, and layers 5 and 6 lie beyond the count.
      load_config(5'd5, 64'h0001_8000_FFFF_0001, 64'hAAAA_5555_0000_7FFF,
                  {$urandom, $urandom}, {$urandom, $urandom});
      set_idling(IDLE_BOTH);
      send_run(16'h0001, 3, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h8000, 1'b0);
      send_pixel(16'h7FFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h5555, 1'b0);
      send_run(16'h0001, 2, 1'b1);
      send_pixel(16'h8000, 1'b1);
      drain_block();

      load_config(5'd16, 64'h4444_3333_2222_1111, 64'h8888_7777_6666_5555,
                  64'hCCCC_BBBB_AAAA_9999, 64'h0000_FFFF_EEEE_DDDD);
      set_idling(IDLE_RECEIVER);
      send_run(16'h1111, 15, 1'b0);
      send_run(16'h0000, 16, 1'b0);
      send_run(16'h9999, 17, 1'b0);
      send_run(16'h1234, 272, 1'b1);
      drain_block();

      load_config(5'd31, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
      set_idling(IDLE_NONE);
      random_traffic(15);
      drain_block();

      load_config(5'd0, '0, '0, '0, '0);
      set_idling(IDLE_SENDER);
      random_traffic(15);
      drain_block();

      load_config(5'($urandom_range(15, 1)), {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
      set_idling(IDLE_NONE);
      receiver_hold = HOLD_CYCLES;
      for (int i = 0; i < 16; i++) begin
         send_pixel(16'(i * 16'h0101), 1'b0);
      end
      set_idling(IDLE_RECEIVER);
      random_traffic(15);
      drain_block();

      load_config(5'($urandom_range(30, 17)), {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
      set_idling(IDLE_BOTH);
      random_traffic(15);
      drain_block();

      load_config(5'd16, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
      set_idling(IDLE_SENDER);
      random_traffic(15);
      drain_block();

      $display("Encoded %0d pixels in %0d images across 8 settings of the layer table,",
               sb.pixels_noted, sb.images_noted);
      $display("checking %0d code bytes after %0d register writes.",
               sb.bytes_checked, sb.writes_noted);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/lmre_pkg.sv
src/lmre_if.sv
src/layer_map_rle_encoder_core.sv
sim/tb.sv
